// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante must be followed by cons in the same cycle
`define CHECK_IMPLY(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// ante must be followed by cons in the next cycle
`define CHECK_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

// cond must never hold
`define CHECK_NEVER(lbl, clk_i, rstn_i, cond) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) \
		else $error("forbidden condition seen");

`endif

// File: design/btc_pkg.sv
package btc_pkg;

	localparam int SLOT_COUNT_DEF = 6;
	localparam int SLOT_W = 4;
	localparam int SLOTS_W = 24;
	localparam int BTN_W = 15;
	localparam int PRES_W = 4;
	localparam int VAL_W = 12;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [SLOT_W-1:0] SLOT_MASK = 4'h0F;
	localparam logic [PRES_W-1:0] BUTTON_COUNT = 4'd15;
	localparam logic [VAL_W-1:0] VALUE_MAX = 12'd4095;

	localparam logic [VAL_W-1:0] MIN_RESET = 12'd1000;
	localparam logic [VAL_W-1:0] MAX_RESET = 12'd2000;

	typedef enum logic [2:0] {
		REG_SLOTS  = 3'd0,
		REG_TOGGLE = 3'd1,
		REG_INVERT = 3'd2,
		REG_MIN    = 3'd3,
		REG_MAX    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [SLOTS_W-1:0] button_slots;
		logic               toggle_mode;
		logic               invert;
		logic [VAL_W-1:0]   channel_min;
		logic [VAL_W-1:0]   channel_max;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic scan;
		logic div_step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic out_free;
	} ctrl_sts_t;

endpackage

// File: design/btc_if.sv
interface btc_in_if;
	logic                            valid;
	logic                            ready;
	logic [btc_pkg::BTN_W-1:0]  buttons_now;
	logic [btc_pkg::PRES_W-1:0] buttons_present;

	modport source (output valid, output buttons_now, output buttons_present, input ready);
	modport sink (input valid, input buttons_now, input buttons_present, output ready);
endinterface

interface btc_out_if;
	logic                           valid;
	logic                           ready;
	logic [btc_pkg::VAL_W-1:0] channel_value;

	modport source (output valid, output channel_value, input ready);
	modport sink (input valid, input channel_value, output ready);
endinterface

// File: design/btc_cfg.sv
module btc_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [btc_pkg::ADDR_W-1:0] paddr,
	input  logic [btc_pkg::DATA_W-1:0] pwdata,
	output logic [btc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output btc_pkg::cfg_t               cfg
);

	btc_pkg::cfg_t cfg_q;
	btc_pkg::cfg_reg_t idx;
	logic wr_en;

	assign pready = 1'b1;
	assign idx = btc_pkg::cfg_reg_t'(paddr[btc_pkg::ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.button_slots <= '0;
			cfg_q.toggle_mode <= 1'b0;
			cfg_q.invert <= 1'b0;
			cfg_q.channel_min <= btc_pkg::MIN_RESET;
			cfg_q.channel_max <= btc_pkg::MAX_RESET;
		end else if (wr_en) begin
			unique case (idx)
				btc_pkg::REG_SLOTS: cfg_q.button_slots <= pwdata[btc_pkg::SLOTS_W-1:0];
				btc_pkg::REG_TOGGLE: cfg_q.toggle_mode <= pwdata[0];
				btc_pkg::REG_INVERT: cfg_q.invert <= pwdata[0];
				btc_pkg::REG_MIN: cfg_q.channel_min <= pwdata[btc_pkg::VAL_W-1:0];
				btc_pkg::REG_MAX: cfg_q.channel_max <= pwdata[btc_pkg::VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			btc_pkg::REG_SLOTS: prdata = {8'd0, cfg_q.button_slots};
			btc_pkg::REG_TOGGLE: prdata = {31'd0, cfg_q.toggle_mode};
			btc_pkg::REG_INVERT: prdata = {31'd0, cfg_q.invert};
			btc_pkg::REG_MIN: prdata = {20'd0, cfg_q.channel_min};
			btc_pkg::REG_MAX: prdata = {20'd0, cfg_q.channel_max};
			default: prdata = '0;
		endcase
	end

endmodule

// File: design/btc_ctrl.sv
module btc_ctrl #(
	parameter int DIV_STEPS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  btc_pkg::ctrl_sts_t     sts,
	output btc_pkg::ctrl_cmd_t     cmd
);

	localparam int StepW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic [StepW-1:0] step_q;

	assign in_ready = (state_q == ST_IDLE);
	assign cmd.capture = in_ready && in_valid;
	assign cmd.scan = (state_q == ST_SCAN);
	assign cmd.div_step = (state_q == ST_DIV);
	assign cmd.finish = (state_q == ST_FIN) && sts.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_SCAN;
			ST_SCAN: state_d = sts.need_div ? ST_DIV : ST_FIN;
			ST_DIV: if (step_q == '0) state_d = ST_FIN;
			ST_FIN: if (sts.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.scan) begin
				step_q <= StepW'(DIV_STEPS - 1);
			end else if (cmd.div_step) begin
				step_q <= step_q - StepW'(1);
			end
		end
	end

endmodule

// File: design/btc_dp.sv
module btc_dp #(
	parameter int SLOT_COUNT = btc_pkg::SLOT_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  btc_pkg::cfg_t               cfg,
	input  btc_pkg::ctrl_cmd_t          cmd,
	output btc_pkg::ctrl_sts_t          sts,
	input  logic [btc_pkg::BTN_W-1:0]  buttons_now,
	input  logic [btc_pkg::PRES_W-1:0] buttons_present,
	btc_out_if.source                   out_ch
);

	localparam int CntW = $clog2(SLOT_COUNT + 1);
	localparam int MagW = btc_pkg::VAL_W + CntW;
	localparam int DivSteps = (MagW + 1) / 2;
	localparam int DivW = 2 * DivSteps;
	localparam int VW = btc_pkg::VAL_W;
	localparam int SLOT_W_L = btc_pkg::SLOT_W;

	// sample and history
	logic [btc_pkg::BTN_W-1:0] now_q, last_btn_q;
	logic [btc_pkg::PRES_W-1:0] present_q;
	logic [VW-1:0] last_q;

	// scan results
	logic level_q, add_neg_q;
	logic [VW-1:0] direct_q, base_q;
	logic [CntW-1:0] den_q, rem_q;
	logic [DivW-1:0] quo_q;

	// output register
	logic out_valid_q;
	logic [VW-1:0] out_val_q;

	// scan logic
	logic [btc_pkg::BTN_W:0] now_pad, last_pad;
	logic [CntW-1:0] n, rank, num, den;
	logic found, level, ok, pressed, rise;
	logic [SLOT_W_L-1:0] slot, btn;
	logic [VW-1:0] lo, hi, held, mid, direct;
	logic [VW:0] diff, mag13, sum13;
	logic [MagW-1:0] prod;

	assign now_pad = {1'b0, now_q};
	assign last_pad = {1'b0, last_btn_q};

	always_comb begin
		n = '0;
		rank = '0;
		found = 1'b0;
		slot = '0;
		btn = '0;
		ok = 1'b0;
		pressed = 1'b0;
		rise = 1'b0;
		for (int k = 0; k < SLOT_COUNT; k++) begin
			slot = cfg.button_slots[SLOT_W_L*k +: SLOT_W_L] & btc_pkg::SLOT_MASK;
			btn = slot - SLOT_W_L'(1);
			ok = (btn < present_q) && (btn < btc_pkg::BUTTON_COUNT);
			pressed = ok && now_pad[btn];
			rise = pressed && !last_pad[btn];
			if (slot != '0) begin
				if (!found && (cfg.toggle_mode ? rise : pressed)) begin
					found = 1'b1;
					rank = n;
				end
				n = n + CntW'(1);
			end
		end
	end

	always_comb begin
		lo = cfg.invert ? cfg.channel_max : cfg.channel_min;
		hi = cfg.invert ? cfg.channel_min : cfg.channel_max;
		held = (last_q == '0) ? lo : last_q;
		sum13 = {1'b0, cfg.channel_min} + {1'b0, cfg.channel_max};
		mid = sum13[VW:1];
		level = 1'b0;
		direct = '0;
		num = '0;
		den = n;
		if (n == '0) begin
			direct = '0;
		end else if (!cfg.toggle_mode) begin
			if (n == CntW'(1)) begin
				direct = found ? hi : lo;
			end else if (found) begin
				level = 1'b1;
				num = rank + CntW'(1);
			end else begin
				direct = lo;
			end
		end else begin
			if (!found) begin
				direct = held;
			end else if (n == CntW'(1)) begin
				direct = (last_q >= mid) ? cfg.channel_min : cfg.channel_max;
			end else begin
				level = 1'b1;
				num = rank;
				den = n - CntW'(1);
			end
		end
	end

	assign diff = {1'b0, cfg.channel_max} - {1'b0, cfg.channel_min};
	assign mag13 = diff[VW] ? ((VW+1)'(0) - diff) : diff;
	assign prod = MagW'(mag13[VW-1:0]) * MagW'(num);

	// two restoring divide steps per cycle
	logic [CntW:0] r1, r2;
	logic [CntW-1:0] r1s, r2s;
	logic ge1, ge2;

	always_comb begin
		r1 = {rem_q, quo_q[DivW-1]};
		ge1 = (r1 >= {1'b0, den_q});
		r1s = ge1 ? CntW'(r1 - {1'b0, den_q}) : r1[CntW-1:0];
		r2 = {r1s, quo_q[DivW-2]};
		ge2 = (r2 >= {1'b0, den_q});
		r2s = ge2 ? CntW'(r2 - {1'b0, den_q}) : r2[CntW-1:0];
	end

	// final combine and clamp
	logic signed [VW+2:0] base_s, part_s, res_s;
	logic [VW-1:0] result;

	always_comb begin
		base_s = $signed({3'd0, base_q});
		part_s = $signed({2'd0, quo_q[VW:0]});
		res_s = add_neg_q ? (base_s - part_s) : (base_s + part_s);
		if (!level_q) begin
			result = direct_q;
		end else if (res_s < 0) begin
			result = '0;
		end else if (res_s > $signed({3'd0, btc_pkg::VALUE_MAX})) begin
			result = btc_pkg::VALUE_MAX;
		end else begin
			result = res_s[VW-1:0];
		end
	end

	assign sts.need_div = level;
	assign sts.out_free = !out_valid_q || out_ch.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.channel_value = out_val_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q <= buttons_now;
			present_q <= buttons_present;
		end
		if (cmd.scan) begin
			level_q <= level;
			direct_q <= direct;
			base_q <= cfg.invert ? cfg.channel_max : cfg.channel_min;
			add_neg_q <= diff[VW] ^ cfg.invert;
			den_q <= den;
			rem_q <= '0;
			quo_q <= DivW'(prod);
		end else if (cmd.div_step) begin
			rem_q <= r2s;
			quo_q <= {quo_q[DivW-3:0], ge1, ge2};
		end
		if (cmd.finish) begin
			out_val_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_q <= '0;
			last_btn_q <= '0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				last_q <= result;
				last_btn_q <= now_q;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/button_to_channel_value.sv
// Maps one sample of joystick button states to one radio channel value, in
// momentary or toggle mode, from up to six configured button slots. An accepted
// sample is captured, scanned and then loaded into the output register when the
// value is an end point, a held value or zero, after which the next sample can
// be taken; a sample that lands on an intermediate level also passes through the
// divide state, where the restoring divider retires two quotient bits per cycle
// for the span times step over slot count (slot count less one in toggle mode).
// One sample is in work at a time; a finished value waits in the output register
// while the next sample is taken in, and a new result holds until that register
// drains.
`include "assert_macros.svh"

module button_to_channel_value #(
	parameter int SLOT_COUNT = btc_pkg::SLOT_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [btc_pkg::ADDR_W-1:0] paddr,
	input  logic [btc_pkg::DATA_W-1:0] pwdata,
	output logic [btc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	btc_in_if.sink                      in_ch,
	btc_out_if.source                   out_ch
);

	localparam int CntW = $clog2(SLOT_COUNT + 1);
	localparam int MagW = btc_pkg::VAL_W + CntW;
	localparam int DivSteps = (MagW + 1) / 2;

	btc_pkg::cfg_t cfg;
	btc_pkg::ctrl_cmd_t cmd;
	btc_pkg::ctrl_sts_t sts;
	logic in_ready;

	assign in_ch.ready = in_ready;

	btc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	btc_ctrl #(
		.DIV_STEPS (DivSteps)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	btc_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.sts             (sts),
		.buttons_now     (in_ch.buttons_now),
		.buttons_present (in_ch.buttons_present),
		.out_ch          (out_ch)
	);

	`CHECK_NEXT(a_accept_then_scan, clk, arst_n, in_ch.valid && in_ch.ready, cmd.scan)
	`CHECK_NEVER(a_no_accept_in_divide, clk, arst_n, in_ch.ready && cmd.div_step)
	`CHECK_IMPLY(a_out_from_finish, clk, arst_n, $rose(out_ch.valid), $past(cmd.finish))

endmodule
